// ===== hdl/mfre_pkg.sv =====
// Shared constants and command/status types for the raster engine.
package mfre_pkg;

	localparam int FRAME_WORDS = 1024;
	localparam int ADDR_W      = 10;
	localparam int WORD_W      = 16;
	localparam int COORD_W     = 8;

	localparam logic [2:0] CMD_PIXEL = 3'd0;
	localparam logic [2:0] CMD_LINE  = 3'd1;
	localparam logic [2:0] CMD_RECT  = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // capture the command fields
		logic line_init;  // set up Bresenham registers
		logic line_step;  // advance one pixel along the line
		logic rect_init;  // set up rectangle walk
		logic rect_step;  // advance one word in the rectangle
		logic clr_step;   // advance clear pointer
		logic rd_issue;   // drive read of current target
		logic wr_en;      // write merged word back
		logic src_pixel;  // target is the current pixel (else rect word)
		logic src_read;   // target is word_index
		logic src_clear;  // target is clear pointer
		logic res_load;   // latch read data as result
		logic res_zero;   // result is zero
	} mfre_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [2:0] command;
		logic       line_last;
		logic       rect_empty;
		logic       rect_last;
		logic       clr_last;
	} mfre_stat_t;

endpackage

// ===== hdl/mfre_ram.sv =====
// Generic single-port RAM with registered read.
module mfre_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read one word a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hdl/mfre_datapath.sv =====
// Datapath: command registers, line and rectangle walkers, store, merge.
module mfre_datapath
	import mfre_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          command,
	input  logic [COORD_W-1:0]  x_start,
	input  logic [COORD_W-1:0]  y_start,
	input  logic [COORD_W-1:0]  x_end,
	input  logic [COORD_W-1:0]  y_end,
	input  logic [COORD_W-1:0]  rect_width,
	input  logic [COORD_W-1:0]  rect_height,
	input  logic                color,
	input  logic [ADDR_W-1:0]   word_index,
	input  mfre_cmd_t           cmd,
	output mfre_stat_t          stat,
	output logic [WORD_W-1:0]   word_value
);

	logic [2:0]         cmd_q;
	logic [COORD_W-1:0] xs_q, ys_q, xe_q, ye_q, rw_q, rh_q;
	logic               color_q;
	logic [ADDR_W-1:0]  widx_q;

	// line walker
	logic               steep_q, ydown_q;
	logic [COORD_W-1:0] maj_q, min_q, maj_end_q;
	logic [COORD_W-1:0] ldx_q, ldy_q;
	logic signed [COORD_W+1:0] err_q;

	// rectangle walker
	logic [3:0]  left_q, right_q, col_q;
	logic [5:0]  row_q, row_end_q;
	logic [WORD_W-1:0] lmask_q, rmask_q;
	logic        rempty_q;

	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] addr_q;
	logic [WORD_W-1:0] mask_q;
	logic              drop_q;
	logic [WORD_W-1:0] rdata, wdata;

	// Capture fields on start
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= command;
			xs_q    <= x_start;
			ys_q    <= y_start;
			xe_q    <= x_end;
			ye_q    <= y_end;
			rw_q    <= rect_width;
			rh_q    <= rect_height;
			color_q <= color;
			widx_q  <= word_index;
		end
	end

	// Line setup
	logic [COORD_W-1:0] adx, ady;
	logic               steep;
	logic [COORD_W-1:0] a0, b0, a1, b1;
	always_comb begin
		adx   = (xe_q >= xs_q) ? xe_q - xs_q : xs_q - xe_q;
		ady   = (ye_q >= ys_q) ? ye_q - ys_q : ys_q - ye_q;
		steep = ady > adx;
		a0 = steep ? ys_q : xs_q;
		b0 = steep ? xs_q : ys_q;
		a1 = steep ? ye_q : xe_q;
		b1 = steep ? xe_q : ye_q;
	end

	logic signed [COORD_W+1:0] err_nx;
	assign err_nx = err_q - $signed({2'b00, ldy_q});

	// Advance line
	always_ff @(posedge clk) begin
		if (cmd.line_init) begin
			steep_q <= steep;
			if (a0 > a1) begin
				maj_q <= a1; min_q <= b1; maj_end_q <= a0;
				ydown_q <= !(b1 < b0);
				ldx_q <= a0 - a1;
			end else begin
				maj_q <= a0; min_q <= b0; maj_end_q <= a1;
				ydown_q <= !(b0 < b1);
				ldx_q <= a1 - a0;
			end
			ldy_q <= steep ? adx : ady;
			err_q <= $signed({2'b00, ((a0 > a1) ? a0 - a1 : a1 - a0) >> 1});
		end else if (cmd.line_step) begin
			maj_q <= maj_q + 1'b1;
			if (err_nx < 0) begin
				min_q <= ydown_q ? min_q - 1'b1 : min_q + 1'b1;
				err_q <= err_nx + $signed({2'b00, ldx_q});
			end else begin
				err_q <= err_nx;
			end
		end
	end

	// Current pixel in panel coordinates
	logic [COORD_W-1:0] px, py;
	always_comb begin
		if (cmd_q == CMD_LINE) begin
			px = steep_q ? min_q : maj_q;
			py = steep_q ? maj_q : min_q;
		end else begin
			px = xs_q;
			py = ys_q;
		end
	end

	// Rectangle setup
	logic [COORD_W:0] wcl, hcl, xlast;
	logic [WORD_W-1:0] lm, rm;
	always_comb begin
		wcl = ({1'b0, xs_q} + rw_q > 9'd128) ? 9'd128 - xs_q : {1'b0, rw_q};
		hcl = ({1'b0, ys_q} + rh_q > 9'd64) ? 9'd64 - ys_q : {1'b0, rh_q};
		xlast = {1'b0, xs_q} + wcl - 1'b1;
		lm = 16'hffff >> xs_q[3:0];
		rm = 16'hffff << (4'd15 - xlast[3:0]);
	end

	// Walk the rectangle word by word
	always_ff @(posedge clk) begin
		if (cmd.rect_init) begin
			rempty_q  <= xs_q >= 8'd128 || ys_q >= 8'd64 || wcl == '0 || hcl == '0;
			left_q    <= xs_q[6:3] >> 1;
			right_q   <= xlast[7:4];
			col_q     <= xs_q[7:4];
			row_q     <= ys_q[5:0];
			row_end_q <= 6'(ys_q + hcl - 1'b1);
			if (xs_q[7:4] == xlast[7:4]) begin
				lmask_q <= lm & rm;
				rmask_q <= lm & rm;
			end else begin
				lmask_q <= lm;
				rmask_q <= rm;
			end
		end else if (cmd.rect_step) begin
			if (col_q == right_q) begin
				col_q <= left_q;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Step clear pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Select target address and mask
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			if (cmd.src_read) begin
				addr_q <= widx_q; mask_q <= '0; drop_q <= 1'b0;
			end else if (cmd.src_clear) begin
				addr_q <= clr_q; mask_q <= '1; drop_q <= 1'b0;
			end else if (cmd.src_pixel) begin
				drop_q <= px >= 8'd128 || py >= 8'd64;
				addr_q <= {1'b0, py[4:0], py[5], px[6:4]};
				mask_q <= 16'h8000 >> px[3:0];
			end else begin
				drop_q <= 1'b0;
				addr_q <= {1'b0, row_q[4:0], row_q[5], col_q[2:0]};
				if (col_q == left_q)       mask_q <= lmask_q;
				else if (col_q == right_q) mask_q <= rmask_q;
				else                       mask_q <= '1;
			end
		end
	end

	// Clear passes always write; drawing writes skip off-panel pixels
	logic ram_we;
	logic [ADDR_W-1:0] ram_addr;
	assign ram_we   = cmd.wr_en && (cmd.src_clear || !drop_q);
	assign ram_addr = cmd.rd_issue ? (cmd.src_clear ? clr_q : addr_q) : addr_q;
	assign wdata = cmd.src_clear ? '0 :
		(color_q ? (rdata | mask_q) : (rdata & ~mask_q));

	mfre_ram #(.WIDTH(WORD_W), .DEPTH(FRAME_WORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// Hold result
	always_ff @(posedge clk) begin
		if (cmd.res_load)      word_value <= rdata;
		else if (cmd.res_zero) word_value <= '0;
	end

	always_comb begin
		stat.command    = cmd_q;
		stat.line_last  = maj_q == maj_end_q;
		stat.rect_empty = rempty_q;
		stat.rect_last  = row_q == row_end_q && col_q == right_q;
		stat.clr_last   = &clr_q;
	end

endmodule

// ===== hdl/mfre_ctrl.sv =====
// Controller state machine sequencing each command.
module mfre_ctrl
	import mfre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  mfre_stat_t stat,
	output logic       busy,
	output logic       done,
	output mfre_cmd_t  cmd
);

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_ADDR  = 4'd3;
	localparam logic [3:0] S_RD    = 4'd4;
	localparam logic [3:0] S_WR    = 4'd5;
	localparam logic [3:0] S_RRD   = 4'd6;
	localparam logic [3:0] S_RWAIT = 4'd7;
	localparam logic [3:0] S_RES   = 4'd8;
	localparam logic [3:0] S_CLR   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0] state_q, state_d;

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.src_clear = 1'b1; cmd.rd_issue = 1'b1;
				cmd.wr_en = 1'b1; cmd.clr_step = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				// zero the result here; a read overwrites it later
				cmd.line_init = 1'b1;
				cmd.rect_init = 1'b1;
				cmd.res_zero  = 1'b1;
				unique case (stat.command) inside
					CMD_PIXEL, CMD_LINE, CMD_READ: state_d = S_ADDR;
					CMD_RECT:  state_d = S_RRD;
					CMD_CLEAR: state_d = S_CLR;
					default:   state_d = S_DONE;
				endcase
			end
			S_ADDR: begin
				cmd.rd_issue  = 1'b1;
				cmd.src_pixel = stat.command != CMD_READ;
				cmd.src_read  = stat.command == CMD_READ;
				state_d = S_RD;
			end
			S_RD: begin
				// registered read in flight
				state_d = (stat.command == CMD_READ) ? S_RES : S_WR;
			end
			S_WR: begin
				cmd.wr_en = 1'b1;
				if (stat.command == CMD_LINE) begin
					cmd.line_step = 1'b1;
					state_d = stat.line_last ? S_DONE : S_ADDR;
				end else if (stat.command == CMD_RECT) begin
					cmd.rect_step = 1'b1;
					state_d = stat.rect_last ? S_DONE : S_RRD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RRD: begin
				if (stat.rect_empty) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d = S_RWAIT;
				end
			end
			S_RWAIT: state_d = S_WR;
			S_RES: begin
				cmd.res_load = 1'b1;
				state_d = S_DONE;
			end
			S_CLR: begin
				cmd.src_clear = 1'b1; cmd.rd_issue = 1'b1;
				cmd.wr_en = 1'b1; cmd.clr_step = 1'b1;
				if (stat.clr_last) state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/mono_framebuffer_raster_engine_core.sv =====
// Top level: 128x64 monochrome raster engine.
// One command at a time; busy is high throughout, and the read-modify-write on the
// single store port sets the rate. After reset the store is cleared word by word
// with busy high. The result strobe done lasts one cycle; the receiver cannot stall it.
module mono_framebuffer_raster_engine_core
	import mfre_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  logic [2:0]          command,
	input  logic [COORD_W-1:0]  x_start,
	input  logic [COORD_W-1:0]  y_start,
	input  logic [COORD_W-1:0]  x_end,
	input  logic [COORD_W-1:0]  y_end,
	input  logic [COORD_W-1:0]  rect_width,
	input  logic [COORD_W-1:0]  rect_height,
	input  logic                color,
	input  logic [ADDR_W-1:0]   word_index,
	output logic [WORD_W-1:0]   word_value
);

	mfre_cmd_t  cmd;
	mfre_stat_t stat;

	mfre_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	mfre_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (command),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.color       (color),
		.word_index  (word_index),
		.cmd         (cmd),
		.stat        (stat),
		.word_value  (word_value)
	);

endmodule
